// ===== design/fn_pkg.sv =====
package fn_pkg;

	// word widths
	localparam int VALUE_BITS = 32;
	localparam int MAG_BITS   = VALUE_BITS - 1;
	localparam int CNT_BITS   = $clog2(MAG_BITS);

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic [MAG_BITS-1:0]          mag_t;
	typedef logic [CNT_BITS-1:0]          cnt_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EUCLID,
		ST_MOD_WAIT,
		ST_DIVT_GO,
		ST_DIVT_WAIT,
		ST_DIVB_GO,
		ST_DIVB_WAIT,
		ST_FINISH
	} state_t;

	// divider request and response
	typedef struct packed {
		logic start;
		mag_t dividend;
		mag_t divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		mag_t quotient;
		mag_t remainder;
	} div_rsp_t;

endpackage

// ===== design/fn_in_if.sv =====
interface fn_in_if;
	import fn_pkg::*;

	logic   valid;
	logic   ready;
	value_t top_value;
	value_t bottom_value;

	modport source (output valid, output top_value, output bottom_value, input ready);
	modport sink (input valid, input top_value, input bottom_value, output ready);

endinterface

// ===== design/fn_out_if.sv =====
interface fn_out_if;
	import fn_pkg::*;

	logic   valid;
	logic   ready;
	value_t reduced_top;
	mag_t   reduced_bottom;
	logic   zero_bottom_flag;

	modport source (output valid, output reduced_top, output reduced_bottom,
		output zero_bottom_flag, input ready);
	modport sink (input valid, input reduced_top, input reduced_bottom,
		input zero_bottom_flag, output ready);

endinterface

// ===== design/fn_divider.sv =====
module fn_divider (
	input  logic             clk,
	input  logic             arst_n,
	input  fn_pkg::div_req_t req,
	output fn_pkg::div_rsp_t rsp
);
	import fn_pkg::*;

	localparam cnt_t LAST = CNT_BITS'(MAG_BITS - 1);

	logic busy_q;
	logic done_q;
	cnt_t cnt_q;
	mag_t rem_q;
	mag_t quo_q;
	mag_t divisor_q;

	logic [MAG_BITS:0]   trial;
	logic [MAG_BITS+1:0] diff;
	logic                ge;
	mag_t                rem_next;
	mag_t                quo_next;

	// one restoring step: bring in next dividend bit, try subtract
	always_comb begin
		trial    = {rem_q, quo_q[MAG_BITS-1]};
		diff     = {1'b0, trial} - {2'b00, divisor_q};
		ge       = !diff[MAG_BITS+1];
		rem_next = ge ? diff[MAG_BITS-1:0] : trial[MAG_BITS-1:0];
		quo_next = {quo_q[MAG_BITS-2:0], ge};
	end

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// ===== design/fraction_normalizer_unit.sv =====
// Reduces a signed fraction top_value/bottom_value to lowest terms with a
// non-negative denominator; the sign goes on reduced_top. A zero numerator
// gives 0/1, a zero denominator gives +1/0 or -1/0 with zero_bottom_flag set,
// and an input of -2^31 is taken as -2^31+1. All arithmetic runs on one shared
// restoring divider that retires one quotient bit per cycle. An item needs
// k modulo passes for Euclid's GCD (k grows with the number of Euclid steps,
// at most about 45 for 31-bit magnitudes) plus two passes for the final
// divisions, and a zero numerator bypasses the divider.
// The input is not ready while an item is in work; a finished word waits in
// the output register, so the next word is taken as soon as the result is
// registered.
module fraction_normalizer_unit (
	input  logic      clk,
	input  logic      arst_n,
	fn_in_if.sink     req,
	fn_out_if.source  rsp
);
	import fn_pkg::*;

	state_t state_q;
	state_t state_d;

	mag_t a_q;
	mag_t b_q;
	mag_t mt_q;
	mag_t mb_q;
	mag_t rt_q;
	mag_t rb_q;
	logic neg_q;
	logic zflag_q;
	logic a_gt_b_q;

	logic   out_valid_q;
	value_t out_top_q;
	mag_t   out_bottom_q;
	logic   out_flag_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic   accept;
	logic   load_out;
	logic   ab_zero;
	logic   a_gt_b;
	mag_t   gcd;
	value_t top_neg;
	value_t bot_neg;
	mag_t   mag_top;
	mag_t   mag_bot;
	value_t signed_top;

	fn_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// input magnitudes, most negative value saturates
	always_comb begin
		top_neg = -req.top_value;
		bot_neg = -req.bottom_value;
		if (!req.top_value[VALUE_BITS-1]) begin
			mag_top = req.top_value[MAG_BITS-1:0];
		end else if (top_neg[VALUE_BITS-1]) begin
			mag_top = '1;
		end else begin
			mag_top = top_neg[MAG_BITS-1:0];
		end
		if (!req.bottom_value[VALUE_BITS-1]) begin
			mag_bot = req.bottom_value[MAG_BITS-1:0];
		end else if (bot_neg[VALUE_BITS-1]) begin
			mag_bot = '1;
		end else begin
			mag_bot = bot_neg[MAG_BITS-1:0];
		end
	end

	// euclid status, gcd is the surviving operand
	always_comb begin
		ab_zero = (a_q == '0) || (b_q == '0);
		a_gt_b  = a_q > b_q;
		gcd     = a_q | b_q;
	end

	assign accept   = req.valid && req.ready;
	assign load_out = (state_q == ST_FINISH) && (!out_valid_q || rsp.ready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = (mag_top == '0) ? ST_FINISH : ST_EUCLID;
				end
			end
			ST_EUCLID: begin
				state_d = ab_zero ? ST_DIVT_GO : ST_MOD_WAIT;
			end
			ST_MOD_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_EUCLID;
				end
			end
			ST_DIVT_GO: begin
				state_d = ST_DIVT_WAIT;
			end
			ST_DIVT_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_DIVB_GO;
				end
			end
			ST_DIVB_GO: begin
				state_d = ST_DIVB_WAIT;
			end
			ST_DIVB_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs: input ready and divider requests
	always_comb begin
		req.ready            = 1'b0;
		div_req.start        = 1'b0;
		div_req.dividend     = mt_q;
		div_req.divisor      = gcd;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
			end
			ST_EUCLID: begin
				div_req.start    = !ab_zero;
				div_req.dividend = a_gt_b ? a_q : b_q;
				div_req.divisor  = a_gt_b ? b_q : a_q;
			end
			ST_DIVT_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = mt_q;
			end
			ST_DIVB_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = mb_q;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			a_q     <= mag_top;
			b_q     <= mag_bot;
			mt_q    <= mag_top;
			mb_q    <= mag_bot;
			zflag_q <= (mag_bot == '0);
			neg_q   <= (mag_bot == '0) ? req.top_value[VALUE_BITS-1]
				: (req.top_value[VALUE_BITS-1] ^ req.bottom_value[VALUE_BITS-1]);
			rt_q    <= '0;
			rb_q    <= MAG_BITS'(1);
		end
		if (state_q == ST_EUCLID) begin
			a_gt_b_q <= a_gt_b;
		end
		if (state_q == ST_MOD_WAIT && div_rsp.done) begin
			if (a_gt_b_q) begin
				a_q <= div_rsp.remainder;
			end else begin
				b_q <= div_rsp.remainder;
			end
		end
		if (state_q == ST_DIVT_WAIT && div_rsp.done) begin
			rt_q <= div_rsp.quotient;
		end
		if (state_q == ST_DIVB_WAIT && div_rsp.done) begin
			rb_q <= div_rsp.quotient;
		end
	end

	// sign goes on the numerator
	assign signed_top = neg_q ? -{1'b0, rt_q} : {1'b0, rt_q};

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_top_q    <= signed_top;
			out_bottom_q <= rb_q;
			out_flag_q   <= zflag_q;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.reduced_top      = out_top_q;
	assign rsp.reduced_bottom   = out_bottom_q;
	assign rsp.zero_bottom_flag = out_flag_q;

endmodule

// ===== tb/fn_reduce_check.sv =====
module fn_reduce_check (
	input  logic clk,
	input  logic arst_n,
	fn_in_if     req,
	fn_out_if    rsp,
	output int   fail_count,
	output int   pending
);
	import fn_pkg::*;

	typedef struct packed {
		value_t num;
		value_t den;
		value_t top;
		mag_t   bottom;
		logic   zflag;
	} reduced_t;

	reduced_t reduced_q[$];
	int       taken_words;
	int       seen_words;
	int       reported;

	assign pending = taken_words - seen_words;

	// magnitude of a two's complement word, most negative value clipped
	function automatic mag_t clipped_mag(value_t v);
		value_t neg_v;
		if (!v[VALUE_BITS-1]) begin
			return v[MAG_BITS-1:0];
		end
		neg_v = -v;
		if (neg_v[VALUE_BITS-1]) begin
			return '1;
		end
		return neg_v[MAG_BITS-1:0];
	endfunction

	// lowest-terms fraction with the sign on the numerator
	function automatic reduced_t reduce_fraction(value_t num, value_t den);
		mag_t     mt;
		mag_t     mb;
		mag_t     a;
		mag_t     b;
		mag_t     g;
		value_t   rt;
		logic     neg;
		reduced_t res;
		mt = clipped_mag(num);
		mb = clipped_mag(den);
		res.num = num;
		res.den = den;
		res.zflag = (mb == '0);
		if (mt == '0) begin
			res.top = '0;
			res.bottom = MAG_BITS'(1);
			return res;
		end
		// euclid by repeated modulo
		a = mt;
		b = mb;
		while (a != '0 && b != '0) begin
			if (a > b) begin
				a = a % b;
			end else begin
				b = b % a;
			end
		end
		g = a + b;
		rt = value_t'({1'b0, mt / g});
		res.bottom = mb / g;
		neg = (mb == '0) ? num[VALUE_BITS-1] : (num[VALUE_BITS-1] ^ den[VALUE_BITS-1]);
		res.top = neg ? -rt : rt;
		return res;
	endfunction

	// predict on accepted input words, compare on accepted output words
	always @(posedge clk or negedge arst_n) begin
		reduced_t want;
		if (!arst_n) begin
			reduced_q.delete();
			taken_words <= 0;
			seen_words <= 0;
			fail_count <= 0;
			reported = 0;
		end else begin
			if (req.valid && req.ready) begin
				reduced_q = {reduced_q, reduce_fraction(req.top_value, req.bottom_value)};
				taken_words <= taken_words + 1;
			end
			if (rsp.valid && rsp.ready) begin
				seen_words <= seen_words + 1;
				if (reduced_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (reported < 10) begin
						$display("unexpected output word %0d/%0d flag %0b",
							rsp.reduced_top, rsp.reduced_bottom, rsp.zero_bottom_flag);
					end
					reported++;
				end else begin
					want = reduced_q.pop_front();
					if (rsp.reduced_top !== want.top || rsp.reduced_bottom !== want.bottom ||
						rsp.zero_bottom_flag !== want.zflag) begin
						fail_count <= fail_count + 1;
						if (reported < 10) begin
							$display("mismatch for %0d/%0d: expected %0d/%0d flag %0b, got %0d/%0d flag %0b",
								want.num, want.den, want.top, want.bottom, want.zflag,
								rsp.reduced_top, rsp.reduced_bottom, rsp.zero_bottom_flag);
						end
						reported++;
					end
				end
			end
		end
	end

endmodule

// ===== tb/testbench.sv =====
module testbench;
	import fn_pkg::*;

	localparam int     DIRECTED_WORDS = 24;
	localparam int     RANDOM_WORDS   = 1150;
	localparam value_t MAX_VAL        = 32'sh7fff_ffff;
	localparam value_t MIN_VAL        = 32'sh8000_0000;
	localparam value_t FIB_HI         = 32'sd1836311903;
	localparam value_t FIB_LO         = 32'sd1134903170;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending;

	fn_in_if  req_ch ();
	fn_out_if rsp_ch ();

	fraction_normalizer_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	fn_reduce_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop
	initial begin
		#200_000_000;
		$display("simulation failed");
		$finish;
	end

	// one of the corner operands
	function automatic value_t corner_value();
		case ($urandom_range(0, 8))
			0: return 0;
			1: return 1;
			2: return -1;
			3: return MIN_VAL;
			4: return MAX_VAL;
			5: return MIN_VAL + 1;
			6: return FIB_HI;
			7: return FIB_LO;
			default: return -FIB_LO;
		endcase
	endfunction

	// random fraction, weighted toward shared factors
	task automatic pick_pair(output value_t num, output value_t den);
		int sel;
		int g;
		sel = $urandom_range(0, 99);
		if (sel < 30) begin
			num = $urandom;
			den = $urandom;
		end else if (sel < 70) begin
			g = $urandom_range(1, 65535);
			num = $urandom_range(0, 32767) * g;
			den = $urandom_range(1, 32767) * g;
			if ($urandom_range(0, 1)) num = -num;
			if ($urandom_range(0, 1)) den = -den;
		end else if (sel < 85) begin
			num = $urandom_range(0, 2000) - 1000;
			den = $urandom_range(0, 2000) - 1000;
		end else begin
			num = corner_value();
			den = ($urandom_range(0, 1)) ? corner_value() : value_t'($urandom);
		end
	endtask

	// hold the word until the block takes it
	task automatic push_word(value_t num, value_t den);
		req_ch.valid <= 1'b1;
		req_ch.top_value <= num;
		req_ch.bottom_value <= den;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// receiver stall pattern
	initial begin
		int mode;
		int span;
		int period;
		rsp_ch.ready <= 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(200, 3000);
			period = $urandom_range(5, 60);
			for (int c = 0; c < span; c++) begin
				@(posedge clk);
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= $urandom_range(0, 1);
					2: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
					default: rsp_ch.ready <= ((c % period) == 0);
				endcase
			end
		end
	end

	// stimulus and verdict
	initial begin
		value_t dir_num[DIRECTED_WORDS];
		value_t dir_den[DIRECTED_WORDS];
		value_t num;
		value_t den;
		int     sent;
		int     burst;
		int     gap;
		int     sel;
		int     waited;
		dir_num = '{0, 0, 0, 7, -7, MIN_VAL, MIN_VAL, MAX_VAL, MIN_VAL, MAX_VAL, MAX_VAL, 1,
			6, -6, -6, 12, MIN_VAL, -1, 1, FIB_HI, -FIB_LO, 0, MIN_VAL, 1};
		dir_den = '{0, 5, -5, 0, 0, 0, MIN_VAL, MAX_VAL, MAX_VAL, MIN_VAL, 1, MAX_VAL,
			-4, 4, -4, 18, 2, -1, 1, FIB_LO, FIB_HI, MIN_VAL, 1, MIN_VAL};
		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.top_value <= '0;
		req_ch.bottom_value <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bursts of words with random gaps
		sent = 0;
		while (sent < DIRECTED_WORDS + RANDOM_WORDS) begin
			burst = $urandom_range(1, 8);
			for (int k = 0; k < burst && sent < DIRECTED_WORDS + RANDOM_WORDS; k++) begin
				if (sent < DIRECTED_WORDS) begin
					num = dir_num[sent];
					den = dir_den[sent];
				end else begin
					pick_pair(num, den);
				end
				push_word(num, den);
				sent++;
			end
			sel = $urandom_range(0, 99);
			if (sel < 25) gap = 0;
			else if (sel < 85) gap = $urandom_range(1, 30);
			else gap = $urandom_range(100, 900);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_ch.valid <= 1'b0;

		// drain
		@(posedge clk);
		waited = 0;
		while (pending != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
